[hw/rtl/sfr_pkg.sv]
// Package for the stream find-and-replace block.
// Holds widths, parameter defaults, register indexes and shared structs.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int REPLACE_MAX_DEF = 8;
	localparam int CHAR_W          = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int LEN_W           = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN   = 3'd0,
		REG_PATTERN_BYTES = 3'd1,
		REG_REPLACE_LEN   = 3'd2,
		REG_REPLACE_BYTES = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]      plen;
		logic [CFG_DATA_W-1:0] pattern;
		logic [LEN_W-1:0]      rlen;
		logic [CFG_DATA_W-1:0] replace;
	} sfr_cfg_t;

	typedef struct packed {
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage

[hw/rtl/sfr_intf.sv]
// Stream and configuration channel interfaces of the find-and-replace block.
// Depends on sfr_pkg for the payload widths.
`timescale 1ns / 1ps

interface sfr_text_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              end_of_text;

	modport source (output valid, output char_in, output end_of_text, input ready);
	modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface sfr_result_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              char_valid;
	logic              run_last;
	logic              text_done;

	modport source (output valid, output char_out, output char_valid, output run_last,
		output text_done, input ready);
	modport sink (input valid, input char_out, input char_valid, input run_last,
		input text_done, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/stream_find_replace.sv]
// Streaming find-and-replace on a byte stream, top level.
// Depends on sfr_pkg, the channel interfaces, sfr_cfg and sfr_cell.
`timescale 1ns / 1ps

// Text bytes enter one per transfer and every leftmost, non-overlapping
// occurrence of the configured pattern is replaced by the replacement text.
// A byte that causes at most one result leaves the input ready for the next, so
// plain text streams at one byte per cycle while the result side accepts; a byte
// that causes n results holds the input while that run drains, since the single
// output register hands out one result per cycle when not stalled. The window is
// a row of PATTERN_MAX cells that shift toward the head each time a byte leaves.
// The user writes configuration only while the block is idle; nothing enforces it.
module stream_find_replace import sfr_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfr_text_if.sink     text,
	sfr_result_if.source result,
	sfr_cfg_if.sink      cfg
);

	localparam int FW  = $clog2(PATTERN_MAX + 1);
	localparam int RW  = $clog2(REPLACE_MAX + 1);
	localparam int CW  = (FW > RW) ? FW : RW;
	localparam int RSW = REPLACE_MAX * CHAR_W;

	sfr_cfg_t regs;

	sfr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	logic [FW-1:0]     fill_q;
	logic              busy_q;
	logic              mode_rep_q;
	logic              last_q;
	logic [CW-1:0]     rem_q;
	logic [RSW-1:0]    rep_sh_q;
	logic              out_vld_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_cv_q;
	logic              out_rl_q;
	logic              out_td_q;

	logic [CHAR_W-1:0]      view [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq;
	logic [PATTERN_MAX-1:0] mvec;
	cell_ctl_t              ctl [PATTERN_MAX];

	logic          slot_free;
	logic          accept;
	logic          drain;
	logic          shift;
	logic [FW-1:0] p_eff;
	logic [RW-1:0] r_eff;
	logic [FW-1:0] fp;
	logic          over;
	logic          eqlen;
	logic          match;
	logic [FW-1:0] nfront;
	logic [RW-1:0] nrep;
	logic [CW-1:0] ntot;
	logic          marker;

	assign slot_free  = !out_vld_q || result.ready;
	assign text.ready = !busy_q && slot_free;
	assign accept     = text.valid && text.ready;
	assign drain      = busy_q && slot_free;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [CHAR_W-1:0] right;
		if (i == PATTERN_MAX - 1) begin : g_end
			assign right = '0;
		end else begin : g_mid
			assign right = view[i+1];
		end
		assign ctl[i].wr    = accept && (fill_q == FW'(i));
		assign ctl[i].shift = shift;
		assign mvec[i]      = eq[i] || (FW'(i) >= p_eff);

		sfr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.din        (text.char_in),
			.pat        (regs.pattern[CHAR_W*i +: CHAR_W]),
			.right_view (right),
			.view       (view[i]),
			.eq         (eq[i])
		);
	end

	always_comb begin
		if (regs.plen == '0) begin
			p_eff = FW'(1);
		end else if (regs.plen > LEN_W'(PATTERN_MAX)) begin
			p_eff = FW'(PATTERN_MAX);
		end else begin
			p_eff = regs.plen[FW-1:0];
		end
		if (regs.rlen > LEN_W'(REPLACE_MAX)) begin
			r_eff = RW'(REPLACE_MAX);
		end else begin
			r_eff = regs.rlen[RW-1:0];
		end
		fp    = fill_q + FW'(1);
		over  = fp > p_eff;
		eqlen = fp == p_eff;
		match = eqlen && (&mvec);
		if (match) begin
			nfront = '0;
		end else if (text.end_of_text) begin
			nfront = fp;
		end else if (over) begin
			nfront = fp - p_eff + FW'(1);
		end else if (eqlen) begin
			nfront = FW'(1);
		end else begin
			nfront = '0;
		end
		nrep   = match ? r_eff : '0;
		ntot   = CW'(nfront) + CW'(nrep);
		marker = text.end_of_text && (ntot == '0);
		shift  = (accept && (nfront != '0)) || (drain && !mode_rep_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			busy_q     <= 1'b0;
			mode_rep_q <= 1'b0;
			last_q     <= 1'b0;
			rem_q      <= '0;
			out_vld_q  <= 1'b0;
		end else if (accept) begin
			fill_q     <= match ? '0 : fp - FW'(nfront != '0);
			busy_q     <= ntot > CW'(1);
			mode_rep_q <= match;
			last_q     <= text.end_of_text;
			rem_q      <= (ntot == '0) ? '0 : ntot - CW'(1);
			out_vld_q  <= (ntot != '0) || marker;
		end else if (drain) begin
			if (!mode_rep_q) begin
				fill_q <= fill_q - FW'(1);
			end
			busy_q    <= rem_q > CW'(1);
			rem_q     <= rem_q - CW'(1);
			out_vld_q <= 1'b1;
		end else if (slot_free) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rep_sh_q   <= regs.replace[RSW-1:0] >> CHAR_W;
			out_char_q <= marker ? '0 : (match ? regs.replace[CHAR_W-1:0] : view[0]);
			out_cv_q   <= !marker;
			out_rl_q   <= ntot <= CW'(1);
			out_td_q   <= text.end_of_text && (ntot <= CW'(1));
		end else if (drain) begin
			if (mode_rep_q) begin
				rep_sh_q   <= rep_sh_q >> CHAR_W;
				out_char_q <= rep_sh_q[CHAR_W-1:0];
			end else begin
				out_char_q <= view[0];
			end
			out_cv_q <= 1'b1;
			out_rl_q <= rem_q == CW'(1);
			out_td_q <= last_q && (rem_q == CW'(1));
		end
	end

	assign result.valid      = out_vld_q;
	assign result.char_out   = out_char_q;
	assign result.char_valid = out_cv_q;
	assign result.run_last   = out_rl_q;
	assign result.text_done  = out_td_q;

endmodule

[hw/rtl/sfr_cfg.sv]
// Configuration register file of the find-and-replace block.
// Depends on sfr_pkg and the sfr_cfg_if interface.
`timescale 1ns / 1ps

module sfr_cfg import sfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfr_cfg_if.sink   cfg,
	output sfr_cfg_t  regs
);

	sfr_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.plen    <= LEN_W'(1);
			regs_q.pattern <= '0;
			regs_q.rlen    <= '0;
			regs_q.replace <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LEN:   regs_q.plen    <= cfg.data[LEN_W-1:0];
				REG_PATTERN_BYTES: regs_q.pattern <= cfg.data;
				REG_REPLACE_LEN:   regs_q.rlen    <= cfg.data[LEN_W-1:0];
				REG_REPLACE_BYTES: regs_q.replace <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/sfr_cell.sv]
// One window cell: holds a text byte, compares it with its pattern byte
// and shifts toward the head of the window. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_cell import sfr_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CHAR_W-1:0] din,
	input  logic [CHAR_W-1:0] pat,
	input  logic [CHAR_W-1:0] right_view,
	output logic [CHAR_W-1:0] view,
	output logic              eq
);

	logic [CHAR_W-1:0] byte_q;

	assign view = ctl.wr ? din : byte_q;
	assign eq   = (view == pat);

	always_ff @(posedge clk) begin
		byte_q <= ctl.shift ? right_view : view;
	end

endmodule

[hw/rtl/sfr_checker.sv]
// Port-level checks for the find-and-replace block and their bind.
// Depends on sfr_pkg; attaches to stream_find_replace.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] char_out,
	input logic              char_valid,
	input logic              run_last,
	input logic              text_done
);

	// A stalled result holds its payload until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out)
		&& $stable(char_valid) && $stable(run_last) && $stable(text_done))
		else $error("result changed while stalled");

	// The end-only marker is always the final result of its text.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> run_last && text_done)
		else $error("marker without run_last and text_done");

	// The final result of a text also closes the run of its byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	// While a run of several results drains, no new byte is taken.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken in the middle of a run");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (text.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.char_out   (result.char_out),
	.char_valid (result.char_valid),
	.run_last   (result.run_last),
	.text_done  (result.text_done)
);

[tb/tb_stream_find_replace.sv]
// Self-checking testbench for the stream find-and-replace block.
// Drives text bytes and register writes, predicts the rewritten stream and
// checks every result transfer. Depends on sfr_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tb_stream_find_replace;
	import sfr_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 120;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 40;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 3'd7;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              eot;
	} text_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              has_char;
		logic              run_last;
		logic              done;
	} rewrite_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_MASK, RX_SPARSE} rx_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              drv_valid = 1'b0;
	logic [CHAR_W-1:0] drv_char  = '0;
	logic              drv_eot   = 1'b0;
	logic              rx_ready  = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	sfr_text_if   text_if();
	sfr_result_if result_if();
	sfr_cfg_if    cfg_if();

	assign text_if.valid       = drv_valid;
	assign text_if.char_in     = drv_char;
	assign text_if.end_of_text = drv_eot;
	assign result_if.ready     = rx_ready;
	assign cfg_if.valid        = cfg_valid;
	assign cfg_if.index        = cfg_index;
	assign cfg_if.data         = cfg_data;

	stream_find_replace dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register copies and window of the predictor.
	logic [LEN_W-1:0]      cur_plen    = 4'd1;
	logic [CFG_DATA_W-1:0] cur_pattern = '0;
	logic [LEN_W-1:0]      cur_rlen    = '0;
	logic [CFG_DATA_W-1:0] cur_replace = '0;
	logic [CHAR_W-1:0]     win_bytes [PATTERN_MAX_DEF];
	int                    win_fill = 0;

	text_item_t text_q[$];
	rewrite_t   run_q[$];
	rewrite_t   rewritten_q[$];

	logic     text_fire = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       tx_gap_max = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic [7:0] rx_mask = 8'hA5;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	int err_count = 0;
	int inputs_taken = 0;
	int results_seen = 0;
	int writes_done = 0;
	int replacements = 0;
	int texts_closed = 0;

	function automatic int pattern_span();
		int pl;
		pl = int'(cur_plen);
		if (pl < 1)
			pl = 1;
		if (pl > PATTERN_MAX_DEF)
			pl = PATTERN_MAX_DEF;
		return pl;
	endfunction

	function automatic void spill_oldest();
		rewrite_t r;
		int k;
		if (win_fill > 0) begin
			r.ch = win_bytes[0];
			r.has_char = 1'b1;
			r.run_last = 1'b0;
			r.done = 1'b0;
			run_q.insert(run_q.size(), r);
			for (k = 1; k < win_fill; k++)
				win_bytes[k - 1] = win_bytes[k];
			win_fill--;
		end
	endfunction

	function automatic void rewrite_byte(logic [CHAR_W-1:0] b, logic eot);
		int pl;
		int rl;
		int k;
		bit hit;
		rewrite_t r;
		pl = pattern_span();
		rl = (cur_rlen > REPLACE_MAX_DEF) ? REPLACE_MAX_DEF : int'(cur_rlen);
		run_q.delete();
		win_bytes[win_fill] = b;
		win_fill++;
		if (win_fill > pl) begin
			// The pattern got shorter: drain unmatched bytes, no match test.
			while (win_fill >= pl && win_fill > 0)
				spill_oldest();
		end else if (win_fill == pl) begin
			hit = 1'b1;
			for (k = 0; k < pl; k++)
				if (win_bytes[k] != cur_pattern[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				for (k = 0; k < rl; k++) begin
					r.ch = cur_replace[8*k +: 8];
					r.has_char = 1'b1;
					r.run_last = 1'b0;
					r.done = 1'b0;
					run_q.insert(run_q.size(), r);
				end
				win_fill = 0;
				replacements++;
			end else begin
				spill_oldest();
			end
		end
		if (eot) begin
			while (win_fill > 0)
				spill_oldest();
			if (run_q.size() == 0) begin
				r.ch = '0;
				r.has_char = 1'b0;
				r.run_last = 1'b0;
				r.done = 1'b0;
				run_q.insert(run_q.size(), r);
			end
			run_q[run_q.size() - 1].done = 1'b1;
			texts_closed++;
		end
		if (run_q.size() != 0)
			run_q[run_q.size() - 1].run_last = 1'b1;
		rewritten_q = {rewritten_q, run_q};
		run_q.delete();
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_PATTERN_LEN:   cur_plen = val[LEN_W-1:0];
		REG_PATTERN_BYTES: cur_pattern = val;
		REG_REPLACE_LEN:   cur_rlen = val[LEN_W-1:0];
		REG_REPLACE_BYTES: cur_replace = val;
		default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_text(string s);
		logic [CFG_DATA_W-1:0] w;
		int k;
		w = '0;
		for (k = 0; k < s.len() && k < 8; k++)
			w[8*k +: 8] = s[k];
		return w;
	endfunction

	always @(negedge clk) begin : text_driver
		text_item_t item;
		if (arst_n && (text_fire || !drv_valid)) begin
			if (gap_left != 0 || text_q.size() == 0) begin
				drv_valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				item = text_q.pop_front();
				drv_valid <= 1'b1;
				drv_char <= item.ch;
				drv_eot <= item.eot;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 20);
					gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
				end
			end
		end
	end

	// The long hold-off lets the block fill up and push back on the text side.
	always @(negedge clk) begin : result_stall
		if (hold_left != 0) begin
			hold_left--;
			rx_ready <= 1'b0;
		end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			rx_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_ALWAYS: rx_ready <= 1'b1;
			RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
			RX_MASK: begin
				rx_ready <= rx_mask[0];
				rx_mask = {rx_mask[0], rx_mask[7:1]};
			end
			default:   rx_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		rewrite_t got;
		rewrite_t want;
		if (!arst_n) begin
			text_fire <= 1'b0;
		end else begin
			text_fire <= drv_valid && text_if.ready;
			if (drv_valid && text_if.ready) begin
				rewrite_byte(drv_char, drv_eot);
				inputs_taken++;
			end
			if (result_if.valid && rx_ready) begin
				got.ch = result_if.char_out;
				got.has_char = result_if.char_valid;
				got.run_last = result_if.run_last;
				got.done = result_if.text_done;
				results_seen++;
				if (rewritten_q.size() == 0) begin
					$error("result transfer with nothing expected: char_out %02h", got.ch);
					err_count++;
				end else begin
					want = rewritten_q.pop_front();
					if (got.ch !== want.ch) begin
						$error("char_out: expected %02h, got %02h", want.ch, got.ch);
						err_count++;
					end
					if (got.has_char !== want.has_char) begin
						$error("char_valid: expected %0b, got %0b", want.has_char, got.has_char);
						err_count++;
					end
					if (got.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
						err_count++;
					end
					if (got.done !== want.done) begin
						$error("text_done: expected %0b, got %0b", want.done, got.done);
						err_count++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		apply_reg(idx, val);
		writes_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_byte(logic [CHAR_W-1:0] b, logic eot);
		text_item_t t;
		t.ch = b;
		t.eot = eot;
		text_q.insert(text_q.size(), t);
	endtask

	task automatic queue_text(string s, bit close);
		int k;
		for (k = 0; k < s.len(); k++)
			queue_byte(s[k], close && (k == s.len() - 1));
	endtask

	task automatic settle();
		int w;
		for (w = 0; w < DRAIN_LIMIT &&
				(text_q.size() != 0 || drv_valid || rewritten_q.size() != 0); w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int n_items, bit eager);
		logic [CHAR_W-1:0]     alpha [3];
		logic [CHAR_W-1:0]     b;
		logic [CFG_DATA_W-1:0] word;
		logic [LEN_W-1:0]      len;
		logic                  eot;
		int pl;
		int k;
		int got;
		int pick;
		bit close;
		for (k = 0; k < 3; k++)
			alpha[k] = 8'($urandom_range(0, 255));
		rx_mode = eager ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 3));
		rx_mask = 8'($urandom_range(1, 255));
		tx_gap_max = eager ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 8);
		if (eager || $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 7))
			0:       len = '0;
			1:       len = LEN_W'($urandom_range(9, 15));
			default: len = LEN_W'($urandom_range(1, 8));
			endcase
			word = {$urandom, $urandom};
			word[LEN_W-1:0] = len;
			write_reg(REG_PATTERN_LEN, word);
		end
		if (eager || $urandom_range(0, 3) != 0) begin
			word = {$urandom, $urandom};
			for (k = 0; k < 8; k++)
				word[8*k +: 8] = alpha[$urandom_range(0, 2)];
			write_reg(REG_PATTERN_BYTES, word);
		end
		if ($urandom_range(0, 3) != 0) begin
			len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(9, 15))
				: LEN_W'($urandom_range(0, 8));
			word = {$urandom, $urandom};
			word[LEN_W-1:0] = len;
			write_reg(REG_REPLACE_LEN, word);
		end
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
		if ($urandom_range(0, 5) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
				{$urandom, $urandom});

		pl = pattern_span();
		close = 1'($urandom_range(0, 1));
		got = 0;
		while (got < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				for (k = 0; k < pl && got < n_items; k++) begin
					got++;
					eot = (k == pl - 1 && $urandom_range(0, 7) == 0) || (got == n_items && close);
					queue_byte(cur_pattern[8*k +: 8], eot);
				end
			end else begin
				got++;
				b = (pick < 85) ? alpha[pick % 3] : 8'($urandom_range(0, 255));
				eot = ($urandom_range(0, 15) == 0) || (got == n_items && close);
				queue_byte(b, eot);
			end
		end
		settle();
	endtask

	initial begin : stimulus
		int p;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		rx_mode = RX_COIN;
		tx_gap_max = 3;

		// Reset settings: a one-byte zero pattern with an empty replacement.
		// The last byte matches and produces nothing, so the end marker shows.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b1);
		settle();

		write_reg(REG_PATTERN_LEN, 64'd3);
		write_reg(REG_PATTERN_BYTES, pack_text("abc"));
		write_reg(REG_REPLACE_LEN, 64'd8);
		write_reg(REG_REPLACE_BYTES, pack_text("12345678"));
		queue_text("xabcabc", 1'b1);
		settle();

		// Longest pattern partly filled, then shortened while bytes wait in the window.
		write_reg(REG_PATTERN_LEN, 64'd8);
		write_reg(REG_PATTERN_BYTES, pack_text("ABCDEFGH"));
		write_reg(REG_REPLACE_LEN, 64'd0);
		queue_text("ABCDE", 1'b0);
		settle();
		write_reg(REG_PATTERN_LEN, 64'd2);
		write_reg(REG_PATTERN_BYTES, pack_text("QZ"));
		queue_text("QZ", 1'b1);
		settle();

		// Lengths out of range clamp; writes to unused indexes are dropped.
		write_reg(REG_PATTERN_LEN, {$urandom, 28'($urandom), 4'h0});
		write_reg(REG_PATTERN_BYTES, {$urandom, 24'($urandom), 8'h71});
		write_reg(REG_REPLACE_LEN, {CFG_DATA_W{1'b1}});
		write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
		write_reg(REG_FIRST_UNUSED, {CFG_DATA_W{1'b1}});
		write_reg(REG_LAST_UNUSED, {$urandom, $urandom});
		queue_text("aqb", 1'b1);
		settle();

		for (p = 0; p < RANDOM_PHASES; p++)
			random_phase(PHASE_ITEMS, p == 0);

		settle();
		if (rewritten_q.size() != 0) begin
			$error("%0d expected results never arrived", rewritten_q.size());
			err_count++;
		end
		$display("Covered %0d text bytes and %0d result transfers over %0d closed texts.",
			inputs_taken, results_seen, texts_closed);
		$display("Saw %0d pattern replacements under %0d register writes.",
			replacements, writes_done);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_intf.sv
hw/rtl/sfr_cfg.sv
hw/rtl/sfr_cell.sv
hw/rtl/stream_find_replace.sv
hw/rtl/sfr_checker.sv
tb/tb_stream_find_replace.sv
